[design/assert_macros.svh]
// Assertion macros for the checker file of the coalescer.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define DSDC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define DSDC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[design/dsdc_pkg.sv]
// Shared widths and item types of the dual-stride dimension coalescer.
// No dependencies; every design module imports it.
package dsdc_pkg;

  localparam int unsigned ExtW      = 32;
  localparam int unsigned StrW      = 48;
  localparam int unsigned DataW     = ExtW + 2 * StrW;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);

  // Last member sits in the lowest bits.
  typedef struct packed {
    logic            last_dim;
    logic [StrW-1:0] stride_b;
    logic [StrW-1:0] stride_a;
    logic [ExtW-1:0] extent;
  } item_t;

  typedef struct packed {
    logic            last_out;
    logic            overflow;
    logic [StrW-1:0] merged_stride_b;
    logic [StrW-1:0] merged_stride_a;
    logic [ExtW-1:0] merged_extent;
  } result_t;

  // Results written by one merge step; second is only set with first.
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

[design/dsdc_merge.sv]
// Open merged dimension and the join/break decision for one item.
// Depends on dsdc_pkg.
module dsdc_merge import dsdc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    advance_i,
  input  item_t   item_i,
  output push_t   push_o,
  output result_t res0_o,
  output result_t res1_o
);

  logic [ExtW-1:0] open_ext_q;
  logic [StrW-1:0] open_sa_q;
  logic [StrW-1:0] open_sb_q;
  logic            open_valid_q;
  logic            open_ov_q;

  logic [2*ExtW-1:0] ext_prod;
  logic              sat;
  logic              match_a;
  logic              match_b;
  logic              join_ok;
  logic              brk;
  result_t           cur;
  result_t           nxt;

  // ext * base == target at full precision, built from two 32x24 partial products.
  function automatic logic stride_follows(logic [ExtW-1:0] ext, logic [StrW-1:0] base,
                                          logic [StrW-1:0] target);
    logic [ExtW+StrW/2-1:0] p_lo;
    logic [ExtW+StrW/2-1:0] p_hi;
    logic [ExtW+StrW-1:0]   sum;
    p_lo = ext * base[StrW/2-1:0];
    p_hi = ext * base[StrW-1:StrW/2];
    sum  = {{(StrW/2){1'b0}}, p_lo} + {p_hi, {(StrW/2){1'b0}}};
    return (sum[ExtW+StrW-1:StrW] == '0) && (sum[StrW-1:0] == target);
  endfunction

  always_comb begin
    ext_prod = open_ext_q * item_i.extent;
    sat      = |ext_prod[2*ExtW-1:ExtW];
    match_a  = stride_follows(open_ext_q, open_sa_q, item_i.stride_a);
    match_b  = stride_follows(open_ext_q, open_sb_q, item_i.stride_b);
    join_ok  = (open_ext_q == ExtW'(1)) || (item_i.extent == ExtW'(1)) || (match_a && match_b);
    brk      = open_valid_q && !join_ok;

    cur.merged_extent   = open_ext_q;
    cur.merged_stride_a = open_sa_q;
    cur.merged_stride_b = open_sb_q;
    cur.overflow        = open_ov_q;
    cur.last_out        = 1'b0;

    if (open_valid_q && join_ok) begin
      // Extent 1 carries no stride of its own: take the new one.
      if (open_ext_q == ExtW'(1)) begin
        nxt.merged_stride_a = item_i.stride_a;
        nxt.merged_stride_b = item_i.stride_b;
      end else begin
        nxt.merged_stride_a = open_sa_q;
        nxt.merged_stride_b = open_sb_q;
      end
      nxt.merged_extent = sat ? '1 : ext_prod[ExtW-1:0];
      nxt.overflow      = open_ov_q | sat;
    end else begin
      nxt.merged_extent   = item_i.extent;
      nxt.merged_stride_a = item_i.stride_a;
      nxt.merged_stride_b = item_i.stride_b;
      nxt.overflow        = 1'b0;
    end
    nxt.last_out = 1'b1;

    push_o.first  = advance_i && (brk || item_i.last_dim);
    push_o.second = advance_i && brk && item_i.last_dim;
    res0_o        = brk ? cur : nxt;
    res1_o        = nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_valid_q <= 1'b0;
      open_ext_q   <= '0;
      open_sa_q    <= '0;
      open_sb_q    <= '0;
      open_ov_q    <= 1'b0;
    end else if (advance_i) begin
      if (item_i.last_dim) begin
        // close the pair: the next item opens a fresh one
        open_valid_q <= 1'b0;
        open_ext_q   <= '0;
        open_sa_q    <= '0;
        open_sb_q    <= '0;
        open_ov_q    <= 1'b0;
      end else begin
        open_valid_q <= 1'b1;
        open_ext_q   <= nxt.merged_extent;
        open_sa_q    <= nxt.merged_stride_a;
        open_sb_q    <= nxt.merged_stride_b;
        open_ov_q    <= nxt.overflow;
      end
    end
  end

endmodule

[design/dsdc_res_fifo.sv]
// Result queue: takes up to two results a cycle, hands out one.
// Depends on dsdc_pkg.
module dsdc_res_fifo import dsdc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  input  result_t wr0_i,
  input  result_t wr1_i,
  input  logic    pop_i,
  output result_t rd_o,
  output logic    not_empty_o,
  output logic    room2_o
);

  result_t             mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q;
  logic [FifoPtrW-1:0] wr_ptr_nx;
  logic [FifoPtrW-1:0] rd_ptr_q;
  logic [FifoPtrW:0]   count_q;
  logic [1:0]          n_push;

  assign n_push      = {1'b0, push_i.first} + {1'b0, push_i.second};
  assign wr_ptr_nx   = wr_ptr_q + FifoPtrW'(1);
  assign rd_o        = mem_q[rd_ptr_q];
  assign not_empty_o = (count_q != '0);
  assign room2_o     = (count_q <= (FifoPtrW + 1)'(FifoDepth - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FifoPtrW'(n_push);
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      end
      count_q <= count_q + (FifoPtrW + 1)'(n_push) - (FifoPtrW + 1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      mem_q[wr_ptr_q] <= wr0_i;
    end
    if (push_i.second) begin
      mem_q[wr_ptr_nx] <= wr1_i;
    end
  end

endmodule

[design/dual_stride_dimension_coalescer_top.sv]
// Dual-stride dimension coalescer, top level.
// Depends on dsdc_pkg, dsdc_merge and dsdc_res_fifo.
//
// Usage:
//   Slave stream: one dimension per transfer, innermost first. tdata holds
//   extent, stride_a, stride_b; tlast marks the outermost dimension.
//   Master stream: coalesced dimensions, innermost first. tdata holds
//   merged_extent, merged_stride_a, merged_stride_b; tuser is the overflow
//   flag; tlast marks the final coalesced dimension of the pair.
//   An input transfer lands in an input register; while the result queue
//   has room for two entries, the merge logic decides join or break and
//   writes zero, one or two results into a four-entry result queue. A result
//   is registered in the queue before it shows on the master side. One
//   dimension is taken per cycle while the queue has room for two results;
//   the queue drains one result a cycle while the master side is ready, so
//   an item that yields two results takes two transfers on the master side.
//   While the master side stalls, the queue fills; once fewer than two
//   entries remain free the held item waits in the input register and tready
//   drops. Reset empties the queue and the input register and closes the
//   open merged dimension.
module dual_stride_dimension_coalescer_top import dsdc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [DataW-1:0] s_axis_tdata_i,  // extent, stride_a, stride_b
  input  logic             s_axis_tlast_i,  // last_dim
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [DataW-1:0] m_axis_tdata_o,  // merged_extent, merged_stride_a, merged_stride_b
  output logic             m_axis_tuser_o,  // overflow
  output logic             m_axis_tlast_o   // last_out
);

  logic    in_valid_q;
  item_t   in_item_q;
  logic    advance;
  logic    room2;
  logic    not_empty;
  logic    pop;
  push_t   push;
  result_t res0;
  result_t res1;
  result_t rd;

  assign advance         = in_valid_q && room2;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign pop             = not_empty && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_item_q.extent   <= s_axis_tdata_i[ExtW-1:0];
      in_item_q.stride_a <= s_axis_tdata_i[ExtW+StrW-1:ExtW];
      in_item_q.stride_b <= s_axis_tdata_i[ExtW+2*StrW-1:ExtW+StrW];
      in_item_q.last_dim <= s_axis_tlast_i;
    end
  end

  dsdc_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_item_q),
    .push_o    (push),
    .res0_o    (res0),
    .res1_o    (res1)
  );

  dsdc_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .wr0_i       (res0),
    .wr1_i       (res1),
    .pop_i       (pop),
    .rd_o        (rd),
    .not_empty_o (not_empty),
    .room2_o     (room2)
  );

  assign m_axis_tvalid_o = not_empty;
  assign m_axis_tdata_o  = {rd.merged_stride_b, rd.merged_stride_a, rd.merged_extent};
  assign m_axis_tuser_o  = rd.overflow;
  assign m_axis_tlast_o  = rd.last_out;

endmodule

[design/dsdc_checker.sv]
// Port-level checks on the coalescer top, attached by bind.
// Depends on dsdc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dsdc_checker import dsdc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tready_o,
  input logic             m_axis_tvalid_o,
  input logic             m_axis_tready_i,
  input logic [DataW-1:0] m_axis_tdata_o,
  input logic             m_axis_tuser_o,
  input logic             m_axis_tlast_o
);

  logic             out_stall;
  logic [DataW+1:0] m_word;

  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign m_word    = {m_axis_tlast_o, m_axis_tuser_o, m_axis_tdata_o};

  // queue is empty once reset has been seen at an edge
  `DSDC_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |=> !m_axis_tvalid_o, "result during reset")

  // input back-pressure only arises from pending results
  `DSDC_ASSERT(a_stall_has_cause, !s_axis_tready_o |-> m_axis_tvalid_o, "tready low, none pending")

  // hold a stalled result
  `DSDC_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid_o && $stable(m_word), "stalled result changed")

endmodule

bind dual_stride_dimension_coalescer_top dsdc_checker u_dsdc_checker (.*);
